@@ rtl/ssrg_pkg.sv @@
// Shared types and constants for the state-space reference generator.
// No dependencies; imported by the top level.
package ssrg_pkg;

	localparam int ADDR_W     = 6;
	localparam int VALUE_W    = 32;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_W      = 32;
	localparam int OUT_STATES = 5;
	localparam int OUT_DATA_W = (2 + OUT_STATES) * OUT_W;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_HOLD  = 4'b1000
	} fsm_t;

endpackage

@@ rtl/state_space_reference_generator_top.sv @@
// Discrete-time linear state-space reference generator, signed fixed point.
// Coefficient and state memories feed one shared multiply-accumulate pipeline.
// Depends on ssrg_pkg.

// A tick transaction runs the Cx row, the Cy row and the STATE_ORDER rows of A
// through a single shared multiply-accumulate fed by one read port on the
// coefficient memory and one on the state memory, so it issues
// (STATE_ORDER + 2) * STATE_ORDER reads, then waits in the drain state until
// the last row leaves the pipeline and in the hold state until the result moves
// to the output register. No new transaction is accepted until it is idle. The
// state memory holds two banks; the new state is written into the idle bank and
// the banks swap at the end of a tick. Both memories reset to zero through
// per-entry valid flags, so there is no clearing pass after reset.
module state_space_reference_generator_top
	import ssrg_pkg::*;
#(
	parameter int STATE_ORDER = 5,
	parameter int WORD_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// load_address [5:0], load_value [37:6], zero [39:38]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind [0]
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_x [31:0], out_y [63:32], state_0 [95:64], state_1 [127:96],
	// state_2 [159:128], state_3 [191:160], state_4 [223:192]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int N          = STATE_ORDER;
	localparam int W          = WORD_WIDTH;
	localparam int F          = W - 8;
	localparam int H          = W / 2;
	localparam int CX_BASE    = N * N;
	localparam int COEF_DEPTH = N * N + 2 * N;
	localparam int ST_BASE    = COEF_DEPTH;
	localparam int ST_END     = ST_BASE + N;
	localparam int AW         = $clog2(COEF_DEPTH);
	localparam int CW         = (N > 1) ? $clog2(N) : 1;
	localparam int RW         = $clog2(N + 2);
	localparam int SW         = $clog2(2 * N);
	localparam int PW         = 2 * W;
	localparam int RNDW       = W + 8;
	localparam int ACW        = W + 11;
	localparam int OUT_ST     = (N < OUT_STATES) ? N : OUT_STATES;
	localparam logic [RW-1:0] ROW_CY    = RW'(1);
	localparam logic [RW-1:0] ROW_A0    = RW'(2);
	localparam logic [RW-1:0] LAST_ROW  = RW'(N + 1);
	localparam logic [CW-1:0] LAST_COL  = CW'(N - 1);
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (F - 1);

	function automatic logic [SW-1:0] st_index(input logic bank, input logic [CW-1:0] col);
		return SW'(col) + (bank ? SW'(N) : SW'(0));
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic [W-1:0] w);
		logic [W+OUT_W-1:0] e;
		e = {{OUT_W{1'b0}}, w};
		return e[OUT_W-1:0];
	endfunction

	fsm_t fsm_q;

	logic            in_fire, load_fire, tick_fire, coef_load, st_load;
	logic            kind;
	logic [ADDR_W-1:0]  load_address;
	logic [VALUE_W-1:0] load_value;
	logic [W-1:0]    load_word;
	logic [CW-1:0]   st_load_idx;

	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   coef_addr_q;
	logic            bank_q;
	logic            iss_vld;
	logic [SW-1:0]   st_raddr;

	logic [W-1:0]    coef_mem [COEF_DEPTH];
	logic [W-1:0]    st_mem [2 * N];
	logic            coef_vld_q [COEF_DEPTH];
	logic            st_vld_q [2 * N];
	logic            st_we;
	logic [SW-1:0]   st_waddr;
	logic [W-1:0]    st_wdata;

	logic            vld_s1, first_s1, last_s1;
	logic [RW-1:0]   row_s1;
	logic [CW-1:0]   col_s1;
	logic [W-1:0]    coef_rd_s1, st_rd_s1;
	logic            coef_ok_s1, st_ok_s1;
	logic [W-1:0]    a1, b1;

	logic            vld_s2, first_s2, last_s2;
	logic [RW-1:0]   row_s2;
	logic signed [W+H:0]     p_lo_s2;
	logic signed [PW-H-1:0]  p_hi_s2;
	logic signed [PW-1:0]    p_lo_x, p_hi_x, prod_sum;

	logic            vld_s3, first_s3, last_s3;
	logic [RW-1:0]   row_s3;
	logic signed [RNDW-1:0]  rnd_s3;
	logic signed [ACW-1:0]   rnd_x;

	logic signed [ACW-1:0]   acc_s4;
	logic            wb_vld_s4;
	logic [RW-1:0]   wb_row_s4;
	logic [ACW-W:0]  acc_top;
	logic            acc_fits;
	logic [W-1:0]    sat_word;
	logic            wb_state, wb_final;

	logic [W-1:0]    res_x_q, res_y_q;
	logic [W-1:0]    res_st_q [OUT_ST];
	logic [W-1:0]    out_x_q, out_y_q;
	logic [W-1:0]    out_st_q [OUT_ST];
	logic            m_tvalid_q;
	logic            out_load;

	assign kind         = s_axis_tuser[0];
	assign load_address = s_axis_tdata[ADDR_W-1:0];
	assign load_value   = s_axis_tdata[ADDR_W +: VALUE_W];
	assign load_word    = W'($signed(load_value));

	assign s_axis_tready = (fsm_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign load_fire     = in_fire && (kind == KIND_LOAD);
	assign tick_fire     = in_fire && (kind == KIND_TICK);
	assign coef_load     = load_fire && (int'(load_address) < COEF_DEPTH);
	assign st_load       = load_fire && (int'(load_address) >= ST_BASE)
	                       && (int'(load_address) < ST_END);
	assign st_load_idx   = CW'(int'(load_address) - ST_BASE);

	assign iss_vld  = (fsm_q == ST_RUN);
	assign st_raddr = st_index(bank_q, col_q);

	// Sequencer: Cx row, Cy row, then the rows of A.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			coef_addr_q <= '0;
			bank_q      <= 1'b0;
		end else begin
			unique case (fsm_q)
				ST_IDLE: begin
					if (tick_fire) begin
						fsm_q       <= ST_RUN;
						row_q       <= '0;
						col_q       <= '0;
						coef_addr_q <= AW'(CX_BASE);
					end
				end
				ST_RUN: begin
					if (col_q == LAST_COL) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
					if (coef_addr_q == AW'(COEF_DEPTH - 1)) begin
						coef_addr_q <= '0;
					end else begin
						coef_addr_q <= coef_addr_q + AW'(1);
					end
					if (row_q == LAST_ROW && col_q == LAST_COL) begin
						fsm_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (wb_final) begin
						fsm_q  <= ST_HOLD;
						bank_q <= ~bank_q;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						fsm_q <= ST_IDLE;
					end
				end
				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

	// Valid flags stand in for the zero reset of both memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_DEPTH; i++) coef_vld_q[i] <= 1'b0;
			for (int i = 0; i < 2 * N; i++) st_vld_q[i] <= 1'b0;
		end else begin
			if (coef_load) coef_vld_q[AW'(load_address)] <= 1'b1;
			if (st_we) st_vld_q[st_waddr] <= 1'b1;
		end
	end

	assign st_we    = st_load || wb_state;
	assign st_waddr = st_load ? st_index(bank_q, st_load_idx)
	                          : st_index(~bank_q, CW'(wb_row_s4 - ROW_A0));
	assign st_wdata = st_load ? load_word : sat_word;

	always_ff @(posedge clk) begin
		if (coef_load) coef_mem[AW'(load_address)] <= load_word;
		coef_rd_s1 <= coef_mem[coef_addr_q];
		coef_ok_s1 <= coef_vld_q[coef_addr_q];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_waddr] <= st_wdata;
		st_rd_s1 <= st_mem[st_raddr];
		st_ok_s1 <= st_vld_q[st_raddr];
	end

	assign a1 = coef_ok_s1 ? coef_rd_s1 : '0;
	assign b1 = st_ok_s1 ? st_rd_s1 : '0;

	assign p_lo_x   = PW'(p_lo_s2);
	assign p_hi_x   = PW'(p_hi_s2);
	assign prod_sum = (p_hi_x <<< H) + p_lo_x + RND_HALF;
	assign rnd_x    = ACW'(rnd_s3);

	assign acc_top  = acc_s4[ACW-1:W-1];
	assign acc_fits = (&acc_top) || !(|acc_top);
	assign sat_word = acc_fits ? acc_s4[W-1:0]
	                : (acc_s4[ACW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
	assign wb_state = wb_vld_s4 && (wb_row_s4 >= ROW_A0);
	assign wb_final = wb_vld_s4 && (wb_row_s4 == LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			wb_vld_s4 <= 1'b0;
		end else begin
			vld_s1    <= iss_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			wb_vld_s4 <= vld_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= (col_q == '0);
		last_s1   <= (col_q == LAST_COL);
		row_s1    <= row_q;
		col_s1    <= col_q;
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		row_s2    <= row_s1;
		p_lo_s2   <= $signed(a1) * $signed({1'b0, b1[H-1:0]});
		p_hi_s2   <= $signed(a1) * $signed(b1[W-1:H]);
		first_s3  <= first_s2;
		last_s3   <= last_s2;
		row_s3    <= row_s2;
		rnd_s3    <= prod_sum[PW-1:F];
		wb_row_s4 <= row_s3;
		if (vld_s3) begin
			acc_s4 <= first_s3 ? rnd_x : acc_s4 + rnd_x;
		end
		if (wb_vld_s4 && wb_row_s4 == '0) res_x_q <= sat_word;
		if (wb_vld_s4 && wb_row_s4 == ROW_CY) res_y_q <= sat_word;
	end

	// The state values are captured as they stream past during the Cx row.
	for (genvar k = 0; k < OUT_ST; k++) begin : g_cap
		always_ff @(posedge clk) begin
			if (vld_s1 && row_s1 == '0 && col_s1 == CW'(k)) res_st_q[k] <= b1;
			if (out_load) out_st_q[k] <= res_st_q[k];
		end
	end

	assign out_load = (fsm_q == ST_HOLD) && (!m_tvalid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata[0 +: OUT_W]     = to_out(out_x_q);
	assign m_axis_tdata[OUT_W +: OUT_W] = to_out(out_y_q);

	for (genvar k = 0; k < OUT_STATES; k++) begin : g_out
		if (k < OUT_ST) begin : g_st
			assign m_axis_tdata[(2 + k) * OUT_W +: OUT_W] = to_out(out_st_q[k]);
		end else begin : g_zero
			assign m_axis_tdata[(2 + k) * OUT_W +: OUT_W] = '0;
		end
	end

endmodule
